>>> rtl/reconnect_supervisor_backoff_top_macros.svh
// Assertion helpers shared by the supervisor RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef RECONNECT_SUPERVISOR_BACKOFF_TOP_MACROS_SVH
`define RECONNECT_SUPERVISOR_BACKOFF_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rsb_pkg.sv
package rsb_pkg;

    // Supervisor states.
    localparam logic [2:0] ST_INIT       = 3'd0;
    localparam logic [2:0] ST_WAIT       = 3'd1;
    localparam logic [2:0] ST_CONNECTING = 3'd2;
    localparam logic [2:0] ST_CONNECTED  = 3'd3;
    localparam logic [2:0] ST_BACKOFF    = 3'd4;
    localparam logic [2:0] ST_STOPPED    = 3'd5;
    localparam logic [2:0] ST_ERROR      = 3'd6;

    // Event codes carried by func.
    localparam logic [2:0] EV_START     = 3'd0;
    localparam logic [2:0] EV_STOP      = 3'd1;
    localparam logic [2:0] EV_LINK_UP   = 3'd2;
    localparam logic [2:0] EV_LINK_DOWN = 3'd3;
    localparam logic [2:0] EV_SESS_UP   = 3'd4;
    localparam logic [2:0] EV_SESS_DOWN = 3'd5;
    localparam logic [2:0] EV_SESS_ERR  = 3'd6;
    localparam logic [2:0] EV_EXPIRED   = 3'd7;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd2;

    // Field widths.
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned CAP_W   = 8;
    localparam int unsigned SHIFT_W = 3;
    localparam int unsigned DELAY_W = 24;

    // Register reset values.
    localparam logic [UNIT_W-1:0]  UNIT_RST  = 16'd1000;
    localparam logic [CAP_W-1:0]   CAP_RST   = 8'd60;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 3'd6;

    localparam int unsigned RETRY_WIDTH_DEF = 8;

    // Per-item command and status flags.
    typedef struct packed {
        logic client_start;
        logic client_stop;
        logic timer_stop;
        logic timer_load;
        logic notify_up;
        logic notify_down;
        logic unexpected_event;
        logic session_ready;
    } t_cmd;

endpackage

>>> rtl/rsb_delay.sv
module rsb_delay import rsb_pkg::*; #(
    parameter int unsigned RETRY_WIDTH = RETRY_WIDTH_DEF
) (
    input  logic                   i_arm,
    input  logic [RETRY_WIDTH-1:0] i_retry,
    input  logic [UNIT_W-1:0]      i_unit,
    input  logic [CAP_W-1:0]       i_cap,
    input  logic [SHIFT_W-1:0]     i_shift_limit,
    output logic [DELAY_W-1:0]     o_delay
);

    logic             below_limit;
    logic [CAP_W-1:0] mult;

    // Below the shift limit the multiplier doubles per retry, else it is the cap.
    assign below_limit = {1'b0, i_retry} < {{(RETRY_WIDTH - 2){1'b0}}, i_shift_limit};
    assign mult        = below_limit ? (CAP_W'(1) << i_retry[2:0]) : i_cap;
    assign o_delay     = i_arm ? DELAY_W'(i_unit * mult) : '0;

endmodule

>>> rtl/rsb_fsm.sv
module rsb_fsm import rsb_pkg::*; #(
    parameter int unsigned RETRY_WIDTH = RETRY_WIDTH_DEF
) (
    input  logic [2:0]             i_state,
    input  logic                   i_link_up,
    input  logic                   i_started,
    input  logic [RETRY_WIDTH-1:0] i_retry,
    input  logic [2:0]             i_func,
    input  logic                   i_start_accepted,
    input  logic                   i_session_confirmed,
    output logic [2:0]             o_state,
    output logic                   o_link_up,
    output logic                   o_started,
    output logic [RETRY_WIDTH-1:0] o_retry,
    output logic                   o_arm,
    output logic [RETRY_WIDTH-1:0] o_arm_retry,
    output t_cmd                   o_cmd
);

    localparam logic [3:0] ACT_NONE        = 4'd0;
    localparam logic [3:0] ACT_START       = 4'd1;
    localparam logic [3:0] ACT_STOP        = 4'd2;
    localparam logic [3:0] ACT_LINKUP_TRY  = 4'd3;
    localparam logic [3:0] ACT_LINKUP      = 4'd4;
    localparam logic [3:0] ACT_LINKDN_LOST = 4'd5;
    localparam logic [3:0] ACT_LINKDN      = 4'd6;
    localparam logic [3:0] ACT_CONNECT     = 4'd7;
    localparam logic [3:0] ACT_FAILURE     = 4'd8;
    localparam logic [3:0] ACT_STOP_CLIENT = 4'd9;
    localparam logic [3:0] ACT_TRY         = 4'd10;
    localparam logic [3:0] ACT_UNEXP       = 4'd11;

    logic [3:0] act;

    // Per-state event table.
    always_comb begin
        act = ACT_UNEXP;
        unique case (i_state)
            ST_INIT: begin
                unique case (i_func)
                    EV_START:     act = ACT_START;
                    EV_STOP:      act = ACT_STOP;
                    EV_LINK_UP:   act = ACT_LINKUP_TRY;
                    EV_LINK_DOWN: act = ACT_LINKDN_LOST;
                    EV_SESS_UP:   act = ACT_CONNECT;
                    default:      act = ACT_UNEXP;
                endcase
            end
            ST_WAIT: begin
                unique case (i_func)
                    EV_STOP:                  act = ACT_STOP;
                    EV_LINK_UP:               act = ACT_LINKUP_TRY;
                    EV_LINK_DOWN:             act = ACT_LINKDN;
                    EV_SESS_UP:               act = ACT_CONNECT;
                    EV_SESS_DOWN, EV_SESS_ERR: act = ACT_FAILURE;
                    default:                  act = ACT_UNEXP;
                endcase
            end
            ST_CONNECTING, ST_CONNECTED: begin
                unique case (i_func)
                    EV_STOP:      act = ACT_STOP;
                    EV_LINK_UP:   act = ACT_LINKUP;
                    EV_LINK_DOWN: act = ACT_LINKDN_LOST;
                    EV_SESS_UP: begin
                        act = (i_state == ST_CONNECTING) ? ACT_CONNECT : ACT_NONE;
                    end
                    EV_SESS_DOWN, EV_SESS_ERR: act = ACT_FAILURE;
                    default:                  act = ACT_UNEXP;
                endcase
            end
            ST_BACKOFF: begin
                unique case (i_func)
                    EV_STOP:                  act = ACT_STOP;
                    EV_LINK_UP:               act = ACT_LINKUP;
                    EV_LINK_DOWN:             act = ACT_LINKDN_LOST;
                    EV_SESS_UP:               act = ACT_CONNECT;
                    EV_SESS_DOWN, EV_SESS_ERR: act = ACT_STOP_CLIENT;
                    EV_EXPIRED:               act = ACT_TRY;
                    default:                  act = ACT_UNEXP;
                endcase
            end
            ST_STOPPED: begin
                unique case (i_func)
                    EV_START:     act = ACT_START;
                    EV_STOP:      act = ACT_STOP;
                    EV_LINK_UP:   act = ACT_LINKUP;
                    EV_LINK_DOWN: act = ACT_LINKDN;
                    EV_SESS_UP:   act = ACT_NONE;
                    default:      act = ACT_UNEXP;
                endcase
            end
            default: begin
                // The error state; the unused code behaves the same way.
                unique case (i_func)
                    EV_START:     act = ACT_START;
                    EV_STOP:      act = ACT_STOP;
                    EV_LINK_UP:   act = ACT_LINKUP;
                    EV_LINK_DOWN: act = ACT_LINKDN;
                    EV_SESS_UP:   act = ACT_CONNECT;
                    default:      act = ACT_UNEXP;
                endcase
            end
        endcase
    end

    // Carry out the selected action.
    always_comb begin
        o_state     = i_state;
        o_link_up   = i_link_up;
        o_started   = i_started;
        o_retry     = i_retry;
        o_arm       = 1'b0;
        o_arm_retry = i_retry;
        o_cmd       = '0;
        unique case (act)
            ACT_START: begin
                if (!i_started) begin
                    o_started   = 1'b1;
                    o_retry     = '0;
                    o_arm_retry = '0;
                    if (i_link_up) begin
                        o_cmd.client_start = 1'b1;
                        if (i_start_accepted) begin
                            o_state = ST_CONNECTING;
                        end else begin
                            o_arm = 1'b1;
                        end
                    end else begin
                        o_state = ST_WAIT;
                    end
                end
            end
            ACT_STOP: begin
                if (i_started) begin
                    o_started         = 1'b0;
                    o_cmd.timer_stop  = 1'b1;
                    o_cmd.client_stop = 1'b1;
                    o_state           = ST_STOPPED;
                end
            end
            ACT_LINKUP_TRY: begin
                o_link_up          = 1'b1;
                o_cmd.client_start = 1'b1;
                o_state            = ST_CONNECTING;
            end
            ACT_LINKUP: begin
                o_link_up = 1'b1;
            end
            ACT_LINKDN_LOST: begin
                o_link_up         = 1'b0;
                o_cmd.timer_stop  = 1'b1;
                o_cmd.client_stop = 1'b1;
                o_state           = ST_WAIT;
            end
            ACT_LINKDN: begin
                o_link_up = 1'b0;
            end
            ACT_CONNECT: begin
                o_cmd.timer_stop = 1'b1;
                o_retry          = '0;
                o_state          = ST_CONNECTED;
            end
            ACT_FAILURE: begin
                o_cmd.client_stop = 1'b1;
                if (i_link_up) begin
                    o_arm = 1'b1;
                end else begin
                    o_cmd.timer_stop = 1'b1;
                    o_state          = ST_WAIT;
                end
            end
            ACT_STOP_CLIENT: begin
                o_cmd.client_stop = 1'b1;
            end
            ACT_TRY: begin
                if (i_link_up) begin
                    o_cmd.client_start = 1'b1;
                    o_state            = ST_CONNECTING;
                end else begin
                    o_state = ST_WAIT;
                end
            end
            ACT_UNEXP: begin
                o_cmd.unexpected_event = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase

        // Loading the backoff timer counts one retry, saturating at all ones.
        if (o_arm) begin
            o_cmd.timer_stop = 1'b1;
            o_cmd.timer_load = 1'b1;
            o_state          = ST_BACKOFF;
            o_retry          = (&o_arm_retry) ? o_arm_retry
                                              : o_arm_retry + RETRY_WIDTH'(1);
        end

        o_cmd.notify_up     = (i_func == EV_SESS_UP);
        o_cmd.notify_down   = (i_func == EV_SESS_DOWN);
        o_cmd.session_ready = (o_state == ST_CONNECTED) && o_link_up && i_session_confirmed;
    end

endmodule

>>> rtl/reconnect_supervisor_backoff_top.sv
// Connection supervisor with exponential backoff.
// Input channel: i_valid, o_stall and the event fields i_func, i_start_accepted and
// i_session_confirmed. An item is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid, i_stall and one result item per input item, carrying the new
// state, the client and timer commands, the backoff delay and the notifications.
// Configuration: i_cfg_valid, o_cfg_ready, i_cfg_index and i_cfg_data write the backoff
// unit, the cap and the shift limit. Ready is always high; write only while the block is idle.
// The edge that accepts an item registers it in the input stage; the block then decodes
// state and event and computes the delay with one 16 by 8 multiply. The edge at which the
// result stage is free registers the result onto the output and updates the supervisor state.
// Throughput is one item per cycle while the receiver does not stall, since the state an
// item leaves is ready for the next item in the following cycle.
// Reset returns the supervisor to init with the link down, not started and no retries,
// and reloads the register defaults. When the receiver stalls, the result holds and the
// pending input item waits in its register; o_stall rises only when both are occupied.
module reconnect_supervisor_backoff_top import rsb_pkg::*; #(
    parameter int unsigned RETRY_WIDTH = RETRY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input item channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_func,
    input  logic                  i_start_accepted,
    input  logic                  i_session_confirmed,
    // Result item channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_state_now,
    output logic                  o_client_start,
    output logic                  o_client_stop,
    output logic                  o_timer_stop,
    output logic                  o_timer_load,
    output logic [DELAY_W-1:0]    o_backoff_delay_ms,
    output logic                  o_notify_up,
    output logic                  o_notify_down,
    output logic                  o_unexpected_event,
    output logic                  o_session_ready,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    `include "reconnect_supervisor_backoff_top_macros.svh"

    // Configuration registers.
    logic [UNIT_W-1:0]  r_unit;
    logic [CAP_W-1:0]   r_cap;
    logic [SHIFT_W-1:0] r_shift;

    // Input stage.
    logic       r_in_valid;
    logic [2:0] r_func;
    logic       r_acc;
    logic       r_conf;

    // Supervisor state.
    logic [2:0]             r_state;
    logic                   r_link_up;
    logic                   r_started;
    logic [RETRY_WIDTH-1:0] r_retry;

    // Result stage.
    logic               r_out_valid;
    logic [2:0]         r_out_state;
    t_cmd               r_out_cmd;
    logic [DELAY_W-1:0] r_out_delay;

    // Decode results.
    logic [2:0]             n_state;
    logic                   n_link_up;
    logic                   n_started;
    logic [RETRY_WIDTH-1:0] n_retry;
    logic                   arm;
    logic [RETRY_WIDTH-1:0] arm_retry;
    t_cmd                   n_cmd;
    logic [DELAY_W-1:0]     n_delay;

    logic out_free;
    logic move;
    logic in_accept;

    // The result register can take an item when it is empty or being drained.
    assign out_free  = !r_out_valid || !i_stall;
    assign move      = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit  <= UNIT_RST;
            r_cap   <= CAP_RST;
            r_shift <= SHIFT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_UNIT:  r_unit  <= i_cfg_data[UNIT_W-1:0];
                CFG_CAP:   r_cap   <= i_cfg_data[CAP_W-1:0];
                CFG_SHIFT: r_shift <= i_cfg_data[SHIFT_W-1:0];
                default:   r_unit  <= r_unit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func <= i_func;
            r_acc  <= i_start_accepted;
            r_conf <= i_session_confirmed;
        end
    end

    rsb_fsm #(
        .RETRY_WIDTH (RETRY_WIDTH)
    ) u_fsm (
        .i_state             (r_state),
        .i_link_up           (r_link_up),
        .i_started           (r_started),
        .i_retry             (r_retry),
        .i_func              (r_func),
        .i_start_accepted    (r_acc),
        .i_session_confirmed (r_conf),
        .o_state             (n_state),
        .o_link_up           (n_link_up),
        .o_started           (n_started),
        .o_retry             (n_retry),
        .o_arm               (arm),
        .o_arm_retry         (arm_retry),
        .o_cmd               (n_cmd)
    );

    rsb_delay #(
        .RETRY_WIDTH (RETRY_WIDTH)
    ) u_delay (
        .i_arm         (arm),
        .i_retry       (arm_retry),
        .i_unit        (r_unit),
        .i_cap         (r_cap),
        .i_shift_limit (r_shift),
        .o_delay       (n_delay)
    );

    // The supervisor state advances exactly when an item moves into the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_link_up <= 1'b0;
            r_started <= 1'b0;
            r_retry   <= '0;
        end else if (move) begin
            r_state   <= n_state;
            r_link_up <= n_link_up;
            r_started <= n_started;
            r_retry   <= n_retry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_state <= n_state;
            r_out_cmd   <= n_cmd;
            r_out_delay <= n_delay;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_state_now        = r_out_state;
    assign o_client_start     = r_out_cmd.client_start;
    assign o_client_stop      = r_out_cmd.client_stop;
    assign o_timer_stop       = r_out_cmd.timer_stop;
    assign o_timer_load       = r_out_cmd.timer_load;
    assign o_backoff_delay_ms = r_out_delay;
    assign o_notify_up        = r_out_cmd.notify_up;
    assign o_notify_down      = r_out_cmd.notify_down;
    assign o_unexpected_event = r_out_cmd.unexpected_event;
    assign o_session_ready    = r_out_cmd.session_ready;

    `RSB_ASSERT_SAME(a_load_enters_backoff, o_valid && o_timer_load,
        o_timer_stop && (o_state_now == ST_BACKOFF), "timer load outside backoff entry")
    `RSB_ASSERT_SAME(a_unexp_no_cmd, o_valid && o_unexpected_event,
        !o_client_start && !o_client_stop && !o_timer_stop && !o_timer_load,
        "command issued on an unexpected event")
    `RSB_ASSERT_SAME(a_delay_only_on_load, o_valid && !o_timer_load,
        o_backoff_delay_ms == '0, "delay shown without a timer load")
    `RSB_ASSERT_NEXT(a_state_follows_result, move, r_state == r_out_state,
        "supervisor state differs from the state just reported")

endmodule
